[sv/brf_pkg.sv]
// types and constants shared by the byte ring fifo
package brf_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 11;
  localparam int CAP_W  = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CAP_W-1:0] CAP_LOG2_RESET = 4'd10;

  typedef logic [CAP_W-1:0] brf_cap_t;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data_in;
    logic [LEN_W-1:0]  read_length;
  } brf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic              last;
    logic              write_taken;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic              is_empty;
    logic              is_full;
  } brf_out_t;

endpackage

[sv/byte_ring_fifo.sv]
// byte fifo over a power-of-two ring held in one synchronous ram
//
// channels: in (in_valid/in_ready/in_data) takes one command beat, either a
// byte to store or a read request for up to read_length bytes. out
// (out_valid/out_ready/out_data) returns result beats; the final beat of a
// command has last set. cfg (cfg_valid/cfg_ready/cfg_data) sets log2 of the
// capacity in use; a cfg beat is always accepted but applied only while nothing is stored.
// a write returns one beat, registered in the cycle after it is taken, with
// write_taken cleared if the ring was full and the byte dropped. a read
// request of n stored bytes (n clamped to MAX_BURST and the fill count)
// returns n beats; the first passes through the ring ram read register and
// the output register, then one per cycle while the receiver keeps up. an empty
// or zero-length read returns one beat with byte_valid low.
// writes run at one per cycle while the receiver keeps up; the next command is
// taken only after a read burst has fully left the ram side.
// every beat carries fill count, free count, empty and full.
// reset clears both pointers (fifo empty), drops any pending beat and
// restores capacity to the full ring; the ram itself is not cleared.
// a stalled receiver holds the output register and freezes the burst.
module byte_ring_fifo #(
  parameter int DEPTH_LOG2 = 10,
  parameter int MAX_BURST  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  brf_pkg::brf_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output brf_pkg::brf_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  brf_pkg::brf_cap_t cfg_data
);
  import brf_pkg::*;

  localparam int PW   = DEPTH_LOG2 + 1;   // free-running pointer width
  localparam int AW   = DEPTH_LOG2;       // ring address width
  localparam int RING = 1 << DEPTH_LOG2;
  localparam int LGW  = 5;                // holds log2 values up to 31
  localparam int CW   = 17;               // common compare width
  localparam logic [LEN_W-1:0] BURST = LEN_W'(MAX_BURST);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t            state, state_next;
  logic [PW-1:0]     wp, wp_next;
  logic [PW-1:0]     rp, rp_next;
  logic [LEN_W-1:0]  rem, rem_next;
  logic [CAP_W-1:0]  cap_lg;
  logic              out_valid_next;
  brf_out_t          out_data_next;

  // ring ram ports
  logic [DATA_W-1:0] mem [RING];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  // derived status
  logic [LGW-1:0]    lg_eff;
  logic [PW-1:0]     cap;
  logic [AW-1:0]     amask;
  logic [PW-1:0]     used;
  logic [PW-1:0]     rp_inc;
  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  burst_n;
  logic              out_free;

  // pack one result beat with its status fields
  function automatic brf_out_t make_result(
    input logic [DATA_W-1:0] d,
    input logic              bv,
    input logic              lst,
    input logic              tk,
    input logic [PW-1:0]     u,
    input logic [PW-1:0]     c
  );
    brf_out_t r;
    r.data_out    = d;
    r.byte_valid  = bv;
    r.last        = lst;
    r.write_taken = tk;
    r.used_count  = CNT_W'(u);
    r.free_count  = CNT_W'((c >= u) ? (c - u) : PW'(0));
    r.is_empty    = (u == PW'(0));
    r.is_full     = (u == c);
    return r;
  endfunction

  // ring ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // effective capacity saturates at the physical ring size
  assign lg_eff = (LGW'(cap_lg) > LGW'(DEPTH_LOG2)) ? LGW'(DEPTH_LOG2) : LGW'(cap_lg);
  assign cap    = PW'(1) << lg_eff;
  assign amask  = AW'(cap - PW'(1));
  assign used   = wp - rp;
  assign rp_inc = rp + PW'(1);

  // burst length: request clamped to max burst, then to fill count
  assign len_c   = (in_data.read_length > BURST) ? BURST : in_data.read_length;
  assign burst_n = (CW'(used) < CW'(len_c)) ? LEN_W'(used) : len_c;

  // output register frees up when empty or being drained this cycle
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    rem_next       = rem;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    wr_en          = 1'b0;
    wr_addr        = wp[AW-1:0] & amask;
    wr_data        = in_data.data_in;
    rd_en          = 1'b0;
    rd_addr        = rp[AW-1:0] & amask;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.cmd == CMD_WRITE) begin
            out_valid_next = 1'b1;
            if (used < cap) begin
              wr_en         = 1'b1;
              wp_next       = wp + PW'(1);
              out_data_next = make_result('0, 1'b0, 1'b1, 1'b1, used + PW'(1), cap);
            end else begin
              // full: byte dropped
              out_data_next = make_result('0, 1'b0, 1'b1, 1'b0, used, cap);
            end
          end else if (burst_n == '0) begin
            // nothing to hand out
            out_valid_next = 1'b1;
            out_data_next  = make_result('0, 1'b0, 1'b1, 1'b0, used, cap);
          end else begin
            // fetch the oldest byte, data shows up next cycle
            rd_en      = 1'b1;
            rem_next   = burst_n;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = make_result(rd_data, 1'b1, rem == LEN_W'(1), 1'b0,
                                       used - PW'(1), cap);
          rp_next        = rp_inc;
          rem_next       = rem - LEN_W'(1);
          if (rem == LEN_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            // overlap the next fetch with this beat
            rd_en   = 1'b1;
            rd_addr = rp_inc[AW-1:0] & amask;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
      cap_lg    <= CAP_LOG2_RESET;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      rem       <= rem_next;
      out_valid <= out_valid_next;
      // capacity changes only while the ring is empty
      if (cfg_valid && cfg_ready && (used == PW'(0))) begin
        cap_lg <= cfg_data;
      end
    end
    out_data <= out_data_next;
  end

endmodule

[test/testbench.sv]
// self-checking testbench for byte_ring_fifo: predicted result beats checked against the dut
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int RING_LOG2     = 10;
  localparam int BURST_MAX     = 64;
  // long receiver hold-off so the output register backs up into the input
  localparam int HOLD_CYCLES   = 300;
  // spare cycles after the last expected beat, before a register write
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 12;
  localparam int SEGMENT_ITEMS = 28;
  localparam int CMD_W         = $bits(brf_in_t);

  // predicts every result beat from the accepted commands and checks the dut against them
  class ring_scoreboard;
    logic [DATA_W-1:0]  ring_bytes [1 << RING_LOG2];
    logic [RING_LOG2:0] wr_ptr;
    logic [RING_LOG2:0] rd_ptr;
    brf_cap_t           cap_log2;
    brf_out_t           expected_beats [$];
    int errors;
    int beats_seen;
    int drops;
    int clamped_reads;
    int empty_reads;
    int ignored_cfg;

    function new();
      wr_ptr        = '0;
      rd_ptr        = '0;
      cap_log2      = CAP_LOG2_RESET;
      errors        = 0;
      beats_seen    = 0;
      drops         = 0;
      clamped_reads = 0;
      empty_reads   = 0;
      ignored_cfg   = 0;
    endfunction

    function int capacity();
      int lg;
      lg = (int'(cap_log2) > RING_LOG2) ? RING_LOG2 : int'(cap_log2);
      return 1 << lg;
    endfunction

    // pointers are free-running, so the fill count is their wrapped difference
    function int stored();
      logic [RING_LOG2:0] diff;
      diff = wr_ptr - rd_ptr;
      return int'(diff);
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    // status fields always reflect the state after this beat
    function brf_out_t make_beat(logic [DATA_W-1:0] data, logic valid, logic last,
                                 logic taken);
      brf_out_t b;
      int fill;
      int cap;
      fill          = stored();
      cap           = capacity();
      b.data_out    = data;
      b.byte_valid  = valid;
      b.last        = last;
      b.write_taken = taken;
      b.used_count  = CNT_W'(fill);
      b.free_count  = CNT_W'(cap - fill);
      b.is_empty    = (fill == 0);
      b.is_full     = (fill == cap);
      return b;
    endfunction

    function void note_command(brf_in_t c);
      int cap;
      int n;
      logic taken;
      logic [DATA_W-1:0] rd_byte;
      cap = capacity();
      if (c.cmd == CMD_WRITE) begin
        taken = (stored() < cap);
        if (taken) begin
          ring_bytes[int'(wr_ptr) & (cap - 1)] = c.data_in;
          wr_ptr = wr_ptr + (RING_LOG2 + 1)'(1);
        end else begin
          drops++;
        end
        expected_beats.push_back(make_beat('0, 1'b0, 1'b1, taken));
      end else begin
        n = int'(c.read_length);
        if (n > BURST_MAX) begin
          n = BURST_MAX;
          clamped_reads++;
        end
        if (n > stored()) n = stored();
        if (n == 0) begin
          empty_reads++;
          expected_beats.push_back(make_beat('0, 1'b0, 1'b1, 1'b0));
        end
        for (int k = 0; k < n; k++) begin
          rd_byte = ring_bytes[int'(rd_ptr) & (cap - 1)];
          rd_ptr  = rd_ptr + (RING_LOG2 + 1)'(1);
          expected_beats.push_back(make_beat(rd_byte, 1'b1, k == n - 1, 1'b0));
        end
      end
    endfunction

    // capacity only moves while the ring is empty
    function void note_capacity(brf_cap_t v);
      if (stored() == 0) begin
        cap_log2 = v;
      end else begin
        ignored_cfg++;
      end
    endfunction

    function void compare(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(brf_out_t got);
      brf_out_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      beats_seen++;
      compare("data_out", CNT_W'(want.data_out), CNT_W'(got.data_out));
      compare("byte_valid", CNT_W'(want.byte_valid), CNT_W'(got.byte_valid));
      compare("last", CNT_W'(want.last), CNT_W'(got.last));
      compare("write_taken", CNT_W'(want.write_taken), CNT_W'(got.write_taken));
      compare("used_count", want.used_count, got.used_count);
      compare("free_count", want.free_count, got.free_count);
      compare("is_empty", CNT_W'(want.is_empty), CNT_W'(got.is_empty));
      compare("is_full", CNT_W'(want.is_full), CNT_W'(got.is_full));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  brf_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  brf_out_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  brf_cap_t  cfg_data  = '0;

  ring_scoreboard ring_sb = new();

  // pacing knobs, moved by the command count
  int send_idle_pct = 30;
  int recv_idle_pct = 88;
  int n_sent        = 0;
  bit hold_request  = 1'b0;

  // register settings for the random segments: small rings to hit full, large ones, saturation
  brf_cap_t segment_caps [6] = '{4'd2, 4'd0, 4'd11, 4'd1, 4'd3, 4'd10};

  byte_ring_fifo #(
    .DEPTH_LOG2(RING_LOG2),
    .MAX_BURST (BURST_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // output beats are checked on the edge that accepts them
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ring_sb.check_beat(out_data);
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  function automatic brf_in_t write_cmd(logic [DATA_W-1:0] b);
    brf_in_t c;
    c.cmd         = CMD_WRITE;
    c.data_in     = b;
    c.read_length = LEN_W'($urandom_range(127));
    return c;
  endfunction

  function automatic brf_in_t read_cmd(logic [LEN_W-1:0] len);
    brf_in_t c;
    c.cmd         = CMD_READ;
    c.data_in     = DATA_W'($urandom_range(255));
    c.read_length = len;
    return c;
  endfunction

  // mostly lengths up to one past the fill count, some zero, some above the burst limit
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    int fill;
    r    = $urandom_range(99);
    fill = ring_sb.stored();
    if (r < 8) return '0;
    if (r < 18) return LEN_W'($urandom_range(65, 127));
    return LEN_W'($urandom_range(1, (fill < 126) ? fill + 1 : 127));
  endfunction

  // one command beat; valid stays up until accepted, then idle cycles at the current rate
  task automatic send_command(brf_in_t c);
    if (n_sent < 90) begin
      send_idle_pct = 30;
      recv_idle_pct = 88;
    end else if (n_sent < 180) begin
      send_idle_pct = 88;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    ring_sb.note_command(c);
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // sender pause: nothing offered until every predicted beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (ring_sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic empty_ring();
    while (ring_sb.stored() > 0) begin
      send_command(read_cmd(LEN_W'($urandom_range(64, 127))));
    end
    settle();
  endtask

  task automatic write_capacity(brf_cap_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ring_sb.note_capacity(v);
    cfg_valid <= 1'b0;
  endtask

  // bursts of writes (sized around the capacity on small rings), then a read or two, with some noise
  task automatic run_segment(int budget);
    int first;
    int cap;
    int nw;
    first = n_sent;
    while (n_sent - first < budget) begin
      cap = ring_sb.capacity();
      if ($urandom_range(9) == 0) begin
        send_command(brf_in_t'(CMD_W'($urandom)));
      end else begin
        nw = (cap <= 8) ? $urandom_range(1, cap + 2) : $urandom_range(1, 12);
        repeat (nw) send_command(write_cmd(DATA_W'($urandom_range(255))));
        repeat ($urandom_range(1, 2)) send_command(read_cmd(pick_length()));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reads on an empty ring, both byte extremes, zero-length read with data stored
    send_command(read_cmd(7'd0));
    send_command(read_cmd(7'd127));
    send_command(write_cmd(8'h00));
    send_command(write_cmd(8'hff));
    send_command(read_cmd(7'd0));
    send_command(read_cmd(7'd1));
    settle();
    // one byte still stored, so this register write must not take effect
    write_capacity(4'd3);
    send_command(read_cmd(7'd64));
    settle();

    // one-entry ring: second write finds it full and is dropped
    write_capacity(4'd0);
    send_command(write_cmd(8'h5a));
    send_command(write_cmd(8'ha5));
    send_command(read_cmd(7'd2));
    settle();

    // register above the ring size saturates to the whole ring
    write_capacity(4'd15);
    // receiver holds off while writes keep coming, so the input stalls
    hold_request = 1'b1;
    repeat (70) send_command(write_cmd(DATA_W'($urandom_range(255))));
    // long reads clamp to the burst limit, then to what is left, then find it empty
    repeat (3) send_command(read_cmd(7'd127));

    foreach (segment_caps[i]) begin
      empty_ring();
      write_capacity(segment_caps[i]);
      run_segment(SEGMENT_ITEMS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands, %0d result beats, ring sizes 1 to 1024 bytes",
             n_sent, ring_sb.beats_seen);
    $display("%0d dropped writes, %0d clamped reads, %0d empty reads, %0d ignored cfg writes",
             ring_sb.drops, ring_sb.clamped_reads, ring_sb.empty_reads, ring_sb.ignored_cfg);
    if (ring_sb.errors == 0 && ring_sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $error("timed out with %0d beats still expected", ring_sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
